@@ rtl/waq_pkg.sv @@
// Package for the waiting queue: sizes, command and status codes, and the
// entry and compare-unit types. Depends on nothing.
`default_nettype none
package waq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int TICK_W = 32;
  localparam int POS_W = 5;

  localparam logic [CNT_W-1:0] QD_CNT = CNT_W'(QUEUE_DEPTH);

  // Command kinds.
  localparam logic [2:0] KIND_ARRIVE   = 3'd0;
  localparam logic [2:0] KIND_WITHDRAW = 3'd1;
  localparam logic [2:0] KIND_SERVE    = 3'd2;
  localparam logic [2:0] KIND_LIST     = 3'd3;
  localparam logic [2:0] KIND_TICK     = 3'd4;
  localparam logic [2:0] KIND_CLEAR    = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TICK_W-1:0] arrival;
  } entry_t;

  typedef struct packed {
    logic              eq;
    logic [TICK_W-1:0] waited;
  } alu_res_t;

  // One-based position, masked to the width of the result field.
  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] n);
    logic [CNT_W+POS_W-1:0] w;
    w = {{POS_W{1'b0}}, n};
    return w[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/waiting_queue_with_cancel.sv @@
// Waiting queue with removal by key; one request is one command, taken only while idle.
// Arrive, tick, clear and the empty cases give a single result; serve captures the head
// key and shifts the rest up; withdraw searches for the key and shifts on a hit; list
// gives one result per entry, one per cycle while the output does not stall.
// A request is taken the cycle after its last result is made. Reset clears the count,
// tick counter and control; entries stay as they are.
`default_nettype none
module waiting_queue_with_cancel (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_kind,
  input  wire logic [waq_pkg::KEY_W-1:0]   in_name_key,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [waq_pkg::KEY_W-1:0]        out_person_key,
  output logic [waq_pkg::POS_W-1:0]        out_position,
  output logic [waq_pkg::TICK_W-1:0]       out_waited_ticks,
  output logic                             out_last
);
  import waq_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // ready for a request
  localparam logic [2:0] S_RESP  = 3'd1;  // single result waits for the output register
  localparam logic [2:0] S_SRCH  = 3'd2;  // withdraw: walk the entries for a key match
  localparam logic [2:0] S_SHEAD = 3'd3;  // serve: capture the head key
  localparam logic [2:0] S_SHIFT = 3'd4;  // move the entries behind a removed one up
  localparam logic [2:0] S_LOUT  = 3'd5;  // list: one entry per result

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              pipe_vld_r, pipe_vld_nxt;
  logic [CNT_W-1:0]  pipe_idx_r, pipe_idx_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [TICK_W-1:0] out_wait_r;
  logic              out_last_r;

  // Result handed to the output register in this cycle.
  logic              emit;
  logic [1:0]        em_status;
  logic [KEY_W-1:0]  em_key;
  logic [POS_W-1:0]  em_pos;
  logic [TICK_W-1:0] em_wait;
  logic              em_last;

  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  entry_t            mem_wr_data;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  entry_t            mem_rd_data;
  alu_res_t          alu_res;

  logic              out_free;
  logic              in_accept;
  logic [CNT_W-1:0]  next_idx;
  logic [CNT_W-1:0]  wr_idx;

  waq_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The one compare/subtract unit works on whatever entry the read port last
  // returned: the search compares its key, the list walk takes its age.
  waq_alu u_alu (
    .key_a    (mem_rd_data.key),
    .key_b    (key_r),
    .tick_now (tick_r),
    .arrival  (mem_rd_data.arrival),
    .res      (alu_res)
  );

  // The block takes a request only when the sequencer is idle. A finished
  // result may still sit in the output register at that time.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign next_idx  = rd_idx_r + CNT_W'(1);
  assign wr_idx    = pipe_idx_r - CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    tick_nxt       = tick_r;
    key_nxt        = key_r;
    rd_idx_nxt     = rd_idx_r;
    pipe_vld_nxt   = pipe_vld_r;
    pipe_idx_nxt   = pipe_idx_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = '0;
    mem_wr_data    = '0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;
    emit           = 1'b0;
    em_status      = ST_OK;
    em_key         = '0;
    em_pos         = '0;
    em_wait        = '0;
    em_last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_name_key;
          case (in_kind)
            KIND_ARRIVE: begin
              res_key_nxt = in_name_key;
              if (count_r == QD_CNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                // Append at the tail, stamped with the current tick.
                mem_wr_en           = 1'b1;
                mem_wr_addr         = count_r[IDX_W-1:0];
                mem_wr_data.key     = in_name_key;
                mem_wr_data.arrival = tick_r;
                count_nxt           = count_r + CNT_W'(1);
                res_status_nxt      = ST_OK;
              end
              state_nxt = S_RESP;
            end
            KIND_WITHDRAW: begin
              rd_idx_nxt   = '0;
              pipe_vld_nxt = 1'b0;
              state_nxt    = S_SRCH;
            end
            KIND_SERVE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                res_key_nxt    = '0;
                state_nxt      = S_RESP;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                state_nxt   = S_SHEAD;
              end
            end
            KIND_LIST: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                res_key_nxt    = '0;
                state_nxt      = S_RESP;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                rd_idx_nxt  = '0;
                state_nxt   = S_LOUT;
              end
            end
            KIND_TICK: begin
              tick_nxt       = tick_r + TICK_W'(1);
              res_status_nxt = ST_OK;
              res_key_nxt    = '0;
              state_nxt      = S_RESP;
            end
            KIND_CLEAR: begin
              count_nxt      = '0;
              res_status_nxt = ST_OK;
              res_key_nxt    = '0;
              state_nxt      = S_RESP;
            end
            default: begin
              // Undefined kinds are dropped without a result.
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          emit      = 1'b1;
          em_status = res_status_r;
          em_key    = res_key_r;
          state_nxt = S_IDLE;
        end
      end

      S_SRCH: begin
        // Reads run one entry ahead of the compare; the front-most match wins.
        if (pipe_vld_r && alu_res.eq) begin
          res_status_nxt = ST_OK;
          res_key_nxt    = key_r;
          rd_idx_nxt     = pipe_idx_r + CNT_W'(1);
          pipe_vld_nxt   = 1'b0;
          state_nxt      = S_SHIFT;
        end else if (rd_idx_r < count_r) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = rd_idx_r[IDX_W-1:0];
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = rd_idx_r;
          rd_idx_nxt   = next_idx;
        end else begin
          res_status_nxt = ST_NOTFOUND;
          res_key_nxt    = key_r;
          pipe_vld_nxt   = 1'b0;
          state_nxt      = S_RESP;
        end
      end

      S_SHEAD: begin
        res_status_nxt = ST_OK;
        res_key_nxt    = mem_rd_data.key;
        rd_idx_nxt     = CNT_W'(1);
        pipe_vld_nxt   = 1'b0;
        state_nxt      = S_SHIFT;
      end

      S_SHIFT: begin
        // Entry read last cycle moves one place toward the head while the
        // next one is read.
        if (pipe_vld_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_idx[IDX_W-1:0];
          mem_wr_data = mem_rd_data;
        end
        if (rd_idx_r < count_r) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = rd_idx_r[IDX_W-1:0];
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = rd_idx_r;
          rd_idx_nxt   = next_idx;
        end else begin
          pipe_vld_nxt = 1'b0;
          count_nxt    = count_r - CNT_W'(1);
          state_nxt    = S_RESP;
        end
      end

      S_LOUT: begin
        // The read of the following entry is issued only when the current
        // one leaves, so a stalled output keeps its data in the read register.
        if (out_free) begin
          emit      = 1'b1;
          em_status = ST_OK;
          em_key    = mem_rd_data.key;
          em_pos    = to_pos(next_idx);
          em_wait   = alu_res.waited;
          em_last   = (next_idx == count_r);
          if (next_idx == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = next_idx[IDX_W-1:0];
            rd_idx_nxt  = next_idx;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register is loaded whenever a result is made; otherwise it
  // empties once its result is taken.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tick_r      <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tick_r      <= tick_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    rd_idx_r     <= rd_idx_nxt;
    pipe_idx_r   <= pipe_idx_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    if (emit) begin
      out_status_r <= em_status;
      out_key_r    <= em_key;
      out_pos_r    <= em_pos;
      out_wait_r   <= em_wait;
      out_last_r   <= em_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_person_key   = out_key_r;
  assign out_position     = out_pos_r;
  assign out_waited_ticks = out_wait_r;
  assign out_last         = out_last_r;

`ifndef NO_ASSERTIONS
  a_arrive_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == KIND_ARRIVE && count_r < QD_CNT)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("arrive into a queue with room did not grow the count");

  a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == KIND_TICK) |=> tick_r == $past(tick_r) + TICK_W'(1))
    else $error("tick request did not advance the tick counter");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOUT && emit && em_last) |=> state_r == S_IDLE && out_last_r)
    else $error("list walk did not finish on its last result");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && state_r != S_IDLE) |-> count_r != '0 && rd_idx_r < count_r)
    else $error("walk read beyond the filled entries");
`endif

endmodule
`default_nettype wire

@@ rtl/waq_mem.sv @@
// Entry storage of the waiting queue: one write port and one read port with
// a registered, enabled read. Depends on waq_pkg.
`default_nettype none
module waq_mem (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [waq_pkg::IDX_W-1:0] wr_addr,
  input  wire waq_pkg::entry_t        wr_data,
  input  wire logic                   rd_en,
  input  wire logic [waq_pkg::IDX_W-1:0] rd_addr,
  output waq_pkg::entry_t             rd_data
);
  import waq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled walk can wait on it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/waq_alu.sv @@
// Shared compare and subtract unit: key match for the search and ticks
// waited for the list walk. Depends on waq_pkg.
`default_nettype none
module waq_alu (
  input  wire logic [waq_pkg::KEY_W-1:0]  key_a,
  input  wire logic [waq_pkg::KEY_W-1:0]  key_b,
  input  wire logic [waq_pkg::TICK_W-1:0] tick_now,
  input  wire logic [waq_pkg::TICK_W-1:0] arrival,
  output waq_pkg::alu_res_t               res
);
  import waq_pkg::*;

  always_comb begin
    res.eq     = (key_a == key_b);
    res.waited = tick_now - arrival;
  end

endmodule
`default_nettype wire
